FILE: hw/rtl/vulb_pkg.sv
// vulb_pkg: shared types and constants for the vu level ballistics block
// used by vulb_cfg, vulb_approach and the top level
package vulb_pkg;

  localparam int LevelW = 16;
  localparam int CoeffW = 16;
  localparam int HoldW  = 8;
  localparam int InW    = 18;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [LevelW-1:0] LevelMax = 16'd32768;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_ATTACK    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DECAY     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HOLD      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 3'd4;

  // reset values
  localparam logic [CoeffW-1:0] ATTACK_RST    = 16'd36045;
  localparam logic [CoeffW-1:0] RELEASE_RST   = 16'd11796;
  localparam logic [CoeffW-1:0] DECAY_RST     = 16'd13107;
  localparam logic [HoldW-1:0]  HOLD_RST      = 8'd12;
  localparam logic [LevelW-1:0] THRESHOLD_RST = 16'd33;

  typedef struct packed {
    logic [CoeffW-1:0] attack_coeff;
    logic [CoeffW-1:0] release_coeff;
    logic [CoeffW-1:0] peak_decay_coeff;
    logic [HoldW-1:0]  hold_ticks;
    logic [LevelW-1:0] redraw_threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEVEL_MUL,
    ST_LEVEL_UPD,
    ST_PEAK,
    ST_DECAY,
    ST_EMIT
  } state_t;

endpackage

FILE: hw/rtl/vu_level_ballistics_peak_hold_core.sv
// vu_level_ballistics_peak_hold_core: level ballistics and peak hold, top level
// depends on vulb_pkg, vulb_cfg and vulb_approach
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid, in_stall, level_in                   | into block
//   out     | out_valid, out_stall, smoothed_level, peak_level, redraw | out of block
//   cfg     | cfg_we, cfg_index, cfg_data                    | into block
//
// each word goes through level multiply, level update, peak (plus decay when the
// held peak decays) and emit, all on the single shared multiplier (level step,
// then peak decay); the next word is taken in the cycle after that load.
// in_stall is high while a word is in process; the next word is taken once
// the previous result sits in the output register.
// a stall on out holds the result register and delays the final load only.
// synchronous reset clears level, peak and hold count to zero.
module vu_level_ballistics_peak_hold_core
  import vulb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [InW-1:0]      level_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LevelW-1:0]   smoothed_level,
  output logic [LevelW-1:0]   peak_level,
  output logic                redraw,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t   cfg;
  state_t state, state_next;

  logic [LevelW-1:0] x_q;
  logic [LevelW-1:0] level_reg;
  logic [LevelW-1:0] peak_reg;
  logic [HoldW-1:0]  hold_count;
  logic [LevelW-1:0] prev_level;
  logic [LevelW-1:0] prev_peak;

  logic              accept;
  logic              issue;
  logic              load_out;
  logic [LevelW-1:0] u_cur;
  logic [LevelW-1:0] u_target;
  logic [CoeffW-1:0] u_coeff;
  logic [LevelW-1:0] u_result;
  logic [LevelW-1:0] x_clamp;
  logic [LevelW:0]   dl;
  logic [LevelW:0]   dp;
  logic              quiet;

  vulb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vulb_approach u_step (
    .clk    (clk),
    .issue  (issue),
    .cur    (u_cur),
    .target (u_target),
    .coeff  (u_coeff),
    .result (u_result)
  );

  // input clamp to 0..1.0 full scale (LevelMax)
  always_comb begin
    if (level_in[InW-1]) begin
      x_clamp = '0;
    end else if (level_in > {2'b00, LevelMax}) begin
      x_clamp = LevelMax;
    end else begin
      x_clamp = level_in[LevelW-1:0];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and unit operand select
  always_comb begin
    state_next = state;
    accept     = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    in_stall   = 1'b1;
    u_cur      = level_reg;
    u_target   = x_q;
    u_coeff    = cfg.release_coeff;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          state_next = ST_LEVEL_MUL;
        end
      end
      ST_LEVEL_MUL: begin
        issue = 1'b1;
        if (x_q > level_reg) begin
          u_coeff = cfg.attack_coeff;
        end
        state_next = ST_LEVEL_UPD;
      end
      ST_LEVEL_UPD: begin
        state_next = ST_PEAK;
      end
      ST_PEAK: begin
        // decay step is issued always, used only once the hold is over
        issue    = 1'b1;
        u_cur    = peak_reg;
        u_target = level_reg;
        u_coeff  = cfg.peak_decay_coeff;
        if (level_reg > peak_reg || hold_count != '0) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_DECAY;
        end
      end
      ST_DECAY: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // level, peak and hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      level_reg  <= '0;
      peak_reg   <= '0;
      hold_count <= '0;
    end else begin
      if (state == ST_LEVEL_UPD) begin
        level_reg <= u_result;
      end
      if (state == ST_PEAK) begin
        if (level_reg > peak_reg) begin
          peak_reg   <= level_reg;
          hold_count <= cfg.hold_ticks;
        end else if (hold_count != '0) begin
          hold_count <= hold_count - 1'b1;
        end
      end
      if (state == ST_DECAY) begin
        peak_reg <= (u_result < level_reg) ? level_reg : u_result;
      end
    end
  end

  // word capture and previous values for the redraw test
  always_ff @(posedge clk) begin
    if (accept) begin
      x_q        <= x_clamp;
      prev_level <= level_reg;
      prev_peak  <= peak_reg;
    end
  end

  // redraw test
  always_comb begin
    dl = (level_reg >= prev_level) ? {1'b0, level_reg} - {1'b0, prev_level}
                                   : {1'b0, prev_level} - {1'b0, level_reg};
    dp = (peak_reg >= prev_peak) ? {1'b0, peak_reg} - {1'b0, prev_peak}
                                 : {1'b0, prev_peak} - {1'b0, peak_reg};
    quiet = (dl < {1'b0, cfg.redraw_threshold}) && (dp < {1'b0, cfg.redraw_threshold});
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      smoothed_level <= level_reg;
      peak_level     <= peak_reg;
      redraw         <= ~quiet;
    end
  end

endmodule

FILE: hw/rtl/vulb_cfg.sv
// vulb_cfg: configuration register file with index decode
// depends on vulb_pkg
module vulb_cfg
  import vulb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_coeff     <= ATTACK_RST;
      cfg.release_coeff    <= RELEASE_RST;
      cfg.peak_decay_coeff <= DECAY_RST;
      cfg.hold_ticks       <= HOLD_RST;
      cfg.redraw_threshold <= THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ATTACK:    cfg.attack_coeff     <= cfg_data;
        CFG_RELEASE:   cfg.release_coeff    <= cfg_data;
        CFG_DECAY:     cfg.peak_decay_coeff <= cfg_data;
        CFG_HOLD:      cfg.hold_ticks       <= cfg_data[HoldW-1:0];
        CFG_THRESHOLD: cfg.redraw_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/vulb_approach.sv
// vulb_approach: shared one-pole step unit, cur + floor((target - cur) * coeff / 65536)
// product registered on issue, result valid the cycle after; depends on vulb_pkg
module vulb_approach
  import vulb_pkg::*;
(
  input  logic              clk,
  input  logic              issue,
  input  logic [LevelW-1:0] cur,
  input  logic [LevelW-1:0] target,
  input  logic [CoeffW-1:0] coeff,
  output logic [LevelW-1:0] result
);

  logic signed [LevelW:0]          diff;
  logic signed [2*LevelW+1:0]      prod;
  logic signed [2*LevelW+1:0]      prod_q;
  logic [LevelW-1:0]               cur_q;
  logic signed [LevelW+1:0]        sum;

  // difference and multiply
  assign diff = $signed({1'b0, target}) - $signed({1'b0, cur});
  assign prod = diff * $signed({1'b0, coeff});

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_q <= prod;
      cur_q  <= cur;
    end
  end

  // arithmetic shift by 16 is floor, then add back the start value
  assign sum    = $signed({2'b00, cur_q}) + prod_q[2*LevelW+1:CoeffW];
  assign result = sum[LevelW-1:0];

endmodule

FILE: bench/vulb_meter_checker.sv
`timescale 1ns / 100ps
// vulb_meter_checker: predicts level, peak and redraw for every word taken by
// vu_level_ballistics_peak_hold_core and compares them with its readout words
// depends on vulb_pkg
module vulb_meter_checker
  import vulb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [InW-1:0]      level_in,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [LevelW-1:0]   smoothed_level,
  input  logic [LevelW-1:0]   peak_level,
  input  logic                redraw,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  outstanding
);

  typedef struct {
    logic [LevelW-1:0] level;
    logic [LevelW-1:0] peak;
    logic              redraw;
  } readout_t;

  cfg_t             regs;
  int               level_now;
  int               peak_now;
  logic [HoldW-1:0] hold_left;
  readout_t         due_readouts[$];
  int               errors = 0;

  assign fail_count = errors;

  // one-pole step: cur + floor((target - cur) * k / 2^16)
  function automatic int step_toward(input int cur, input int target,
                                     input logic [CoeffW-1:0] k);
    longint prod;
    prod = longint'(target - cur) * longint'(k);
    return cur + int'(prod >>> 16);
  endfunction

  function automatic int magnitude(input int a);
    return (a < 0) ? -a : a;
  endfunction

  // advance the meter by one reading and queue the readout it should give
  function automatic void meter_advance(input logic signed [InW-1:0] raw);
    int       target;
    int       prev_level;
    int       prev_peak;
    int       thr;
    readout_t r;
    prev_level = level_now;
    prev_peak  = peak_now;
    thr        = int'(regs.redraw_threshold);

    // readings outside the scale pin to 0 or full scale
    if (raw < 0)
      target = 0;
    else if (raw > int'(LevelMax))
      target = int'(LevelMax);
    else
      target = int'(raw);

    // attack only on a strictly rising reading
    if (target > level_now)
      level_now = step_toward(level_now, target, regs.attack_coeff);
    else
      level_now = step_toward(level_now, target, regs.release_coeff);

    // peak: capture, hold, then decay but never below the level
    if (level_now > peak_now) begin
      peak_now  = level_now;
      hold_left = regs.hold_ticks;
    end else if (hold_left != '0) begin
      hold_left = hold_left - 1'b1;
    end else begin
      peak_now = step_toward(peak_now, level_now, regs.peak_decay_coeff);
      if (peak_now < level_now)
        peak_now = level_now;
    end

    r.level  = LevelW'(level_now);
    r.peak   = LevelW'(peak_now);
    r.redraw = !(magnitude(prev_level - level_now) < thr &&
                 magnitude(prev_peak - peak_now) < thr);
    due_readouts.push_back(r);
  endfunction

  task automatic check_field(input string field, input logic [LevelW-1:0] want,
                             input logic [LevelW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // track config writes, predict on input words, compare on readout words
  always @(posedge clk) begin
    readout_t want;
    if (rst) begin
      regs.attack_coeff     = ATTACK_RST;
      regs.release_coeff    = RELEASE_RST;
      regs.peak_decay_coeff = DECAY_RST;
      regs.hold_ticks       = HOLD_RST;
      regs.redraw_threshold = THRESHOLD_RST;
      level_now = 0;
      peak_now  = 0;
      hold_left = '0;
      due_readouts.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATTACK:    regs.attack_coeff     = cfg_data;
          CFG_RELEASE:   regs.release_coeff    = cfg_data;
          CFG_DECAY:     regs.peak_decay_coeff = cfg_data;
          CFG_HOLD:      regs.hold_ticks       = cfg_data[HoldW-1:0];
          CFG_THRESHOLD: regs.redraw_threshold = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall)
        meter_advance(level_in);

      if (out_valid && !out_stall) begin
        if (due_readouts.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual level %0d peak %0d redraw %0b",
                   $time, smoothed_level, peak_level, redraw);
        end else begin
          want = due_readouts.pop_front();
          check_field("smoothed_level", want.level, smoothed_level);
          check_field("peak_level", want.peak, peak_level);
          check_field("redraw", LevelW'(want.redraw), LevelW'(redraw));
        end
      end

      outstanding <= due_readouts.size();
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// testbench: drives readings and register writes into
// vu_level_ballistics_peak_hold_core and gives the verdict
// depends on vulb_pkg, the core and vulb_meter_checker
module testbench;
  import vulb_pkg::*;

  localparam int HoldOffCycles = 120;
  localparam int SettleCycles  = 10;
  localparam int RandomPhases  = 6;
  localparam int PhaseItems    = 165;
  localparam int SweepLen      = 13;
  // input extremes, sign and alternating bit patterns, then a short quiet tail
  localparam int Sweep [SweepLen] = '{0, 1, 16384, 32767, 32768, 32769, 131071,
                                      -131072, -1, 'h15555, 'h2AAAA, 0, 0};

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;
  typedef enum {SEG_HIT, SEG_TONE, SEG_WANDER, SEG_WILD} segment_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [InW-1:0]      level_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [LevelW-1:0]   smoothed_level;
  logic [LevelW-1:0]   peak_level;
  logic                redraw;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int fail_count;
  int outstanding;
  int hold_off_req = 0;
  int hold_off_seen = 0;
  int burst_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  vu_level_ballistics_peak_hold_core dut (
    .clk, .rst, .in_valid, .in_stall, .level_in,
    .out_valid, .out_stall, .smoothed_level, .peak_level, .redraw,
    .cfg_we, .cfg_index, .cfg_data
  );

  vulb_meter_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .level_in,
    .out_valid, .out_stall, .smoothed_level, .peak_level, .redraw,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .outstanding
  );

  // offer one reading word, inside bursts with random gaps between them
  task automatic offer(input logic [InW-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 20);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                        : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    level_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait for every readout still owed
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // write all registers, optionally poking the unused indexes as well
  task automatic program_regs(input cfg_t c, input bit poke_unused);
    logic [CfgDataW-1:0] hold_word;
    hold_word = CfgDataW'($urandom);
    hold_word[HoldW-1:0] = c.hold_ticks;
    cfg_we <= 1'b1;
    cfg_index <= CFG_ATTACK;    cfg_data <= c.attack_coeff;     @(posedge clk);
    cfg_index <= CFG_RELEASE;   cfg_data <= c.release_coeff;    @(posedge clk);
    cfg_index <= CFG_DECAY;     cfg_data <= c.peak_decay_coeff; @(posedge clk);
    cfg_index <= CFG_HOLD;      cfg_data <= hold_word;          @(posedge clk);
    cfg_index <= CFG_THRESHOLD; cfg_data <= c.redraw_threshold; @(posedge clk);
    if (poke_unused) begin
      for (int k = int'(CFG_THRESHOLD) + 1; k < (1 << CfgIdxW); k++) begin
        cfg_index <= CfgIdxW'(k);
        cfg_data  <= CfgDataW'($urandom);
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CoeffW-1:0] pick_coeff();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CoeffW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic cfg_t pick_settings();
    cfg_t c;
    c.attack_coeff     = pick_coeff();
    c.release_coeff    = pick_coeff();
    c.peak_decay_coeff = pick_coeff();
    case ($urandom_range(0, 5))
      0:       c.hold_ticks = '0;
      1:       c.hold_ticks = '1;
      2:       c.hold_ticks = HoldW'(1);
      default: c.hold_ticks = HoldW'($urandom_range(2, 16));
    endcase
    case ($urandom_range(0, 6))
      0:       c.redraw_threshold = '0;
      1:       c.redraw_threshold = '1;
      2:       c.redraw_threshold = LevelMax;
      default: c.redraw_threshold = LevelW'($urandom_range(1, 400));
    endcase
    return c;
  endfunction

  // meter-like signal: hits with quiet tails, steady tones, drift and noise
  task automatic random_phase(input int items, input bit with_hold_off);
    int       sent;
    int       len;
    int       base;
    int       v;
    segment_t kind;
    sent = 0;
    v = 0;
    while (sent < items) begin
      kind = segment_t'($urandom_range(0, 3));
      len  = $urandom_range(4, 40);
      base = $urandom_range(0, 32768);
      for (int i = 0; i < len && sent < items; i++) begin
        case (kind)
          SEG_HIT:
            v = (i < 2) ? int'($urandom_range(16000, 32768)) : int'($urandom_range(0, 1500));
          SEG_TONE: begin
            v = base;
            if ($urandom_range(0, 9) == 0)
              v = base + int'($urandom_range(0, 6)) - 3;
          end
          SEG_WANDER: begin
            v = v + int'($urandom_range(0, 3000)) - 1500;
            if (v < -600 || v > 33600)
              v = base;
          end
          default:
            v = int'($urandom_range(0, (1 << InW) - 1));
        endcase
        if (with_hold_off && sent == 30)
          hold_off_req <= hold_off_req + 1;
        offer(InW'(v));
        sent++;
      end
    end
  endtask

  // readout side stalls on its own pattern, with one long hold-off on request
  initial begin : receiver
    rx_mode_t mode;
    int       span;
    forever begin
      if (hold_off_req != hold_off_seen) begin
        hold_off_seen = hold_off_req;
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
      end else begin
        mode = rx_mode_t'($urandom_range(0, 3));
        span = $urandom_range(20, 150);
        for (int c = 0; c < span && hold_off_req == hold_off_seen; c++) begin
          case (mode)
            RX_OPEN:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
            RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
            default:  out_stall <= (c % 4 == 3);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    cfg_t c;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // input range sweep with reset settings
    for (int i = 0; i < SweepLen; i++)
      offer(InW'(Sweep[i]));
    drain();

    // full-scale coefficients: release lands exactly, equal reading, no hold,
    // zero threshold so every word redraws
    c.attack_coeff     = '1;
    c.release_coeff    = '1;
    c.peak_decay_coeff = '1;
    c.hold_ticks       = '0;
    c.redraw_threshold = '0;
    program_regs(c, 1'b1);
    offer(InW'(20000));
    offer(InW'(10000));
    offer(InW'(10000));
    offer(InW'(30000));
    offer(InW'(5000));
    offer(InW'(5000));
    offer(InW'(0));
    drain();

    // frozen filter, longest hold, threshold above range
    c.attack_coeff     = '0;
    c.release_coeff    = '0;
    c.peak_decay_coeff = '0;
    c.hold_ticks       = '1;
    c.redraw_threshold = '1;
    program_regs(c, 1'b0);
    offer(InW'(32768));
    offer(InW'(0));
    offer(InW'(32768));
    drain();

    // random settings per phase, the second one with a long readout hold-off
    for (int p = 0; p < RandomPhases; p++) begin
      program_regs(pick_settings(), ($urandom_range(0, 1) == 1));
      random_phase(PhaseItems, (p == 1));
      drain();
    end

    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/vulb_pkg.sv
hw/rtl/vulb_cfg.sv
hw/rtl/vulb_approach.sv
hw/rtl/vu_level_ballistics_peak_hold_core.sv
bench/vulb_meter_checker.sv
bench/testbench.sv
